// ===== hw/rtl/cfl_pkg.sv =====
// shared types, frame codes and constants of the command frame link
`timescale 1ns / 1ps

package cfl_pkg;

  // request kinds carried with each input beat
  localparam logic REQ_RX    = 1'b0;
  localparam logic REQ_REPLY = 1'b1;

  // frame delimiters
  localparam logic [7:0] RX_HEADER  = 8'hFB;
  localparam logic [7:0] RX_TRAILER = 8'hFC;
  localparam logic [7:0] TX_HEADER  = 8'hFD;
  localparam logic [7:0] TX_TRAILER = 8'hFE;

  // command codes
  localparam logic [7:0] CMD_KEY    = 8'h01;
  localparam logic [7:0] CMD_ERROR  = 8'h03;
  localparam logic [7:0] CMD_WHEEL  = 8'h04;
  localparam logic [7:0] CMD_LIMITS = 8'h05;
  localparam logic [7:0] CMD_RUN    = 8'h06;
  localparam logic [7:0] CMD_HEART  = 8'h07;
  localparam logic [7:0] CMD_STUDY  = 8'h08;

  // study command and reply fields
  localparam logic [7:0] STUDY_SELECT    = 8'd20;
  localparam logic [7:0] STUDY_REQ_START = 8'd1;
  localparam logic [7:0] STUDY_REQ_STOP  = 8'd2;
  localparam logic [7:0] STUDY_REPLY_SUB = 8'd6;
  localparam logic [7:0] STUDY_RPT_BUSY  = 8'd1;
  localparam logic [7:0] STUDY_RPT_DONE  = 8'd2;

  // study stages
  localparam logic [1:0] STAGE_IDLE    = 2'd0;
  localparam logic [1:0] STAGE_RUNNING = 2'd2;
  localparam logic [1:0] STAGE_SUCCESS = 2'd3;
  localparam logic [1:0] STUDY_VAL_START = 2'd1;
  localparam logic [1:0] STUDY_VAL_STOP  = 2'd0;

  // limit checking
  localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;
  localparam logic [7:0] INCLINE_MAX   = 8'd30;
  localparam logic [7:0] STATUS_HOLD   = 8'd4;

  // frame geometry
  localparam int FRAME_LEN = 9;
  localparam int IDX_W     = $clog2(FRAME_LEN);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);
  localparam int BODY_LEN  = FRAME_LEN - 1;

  typedef logic [FRAME_LEN-1:0][7:0] frame_t;
  typedef logic [BODY_LEN-1:0][7:0]  body_t;

  // one registered input beat
  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
    logic [1:0] study_stage;
    logic [7:0] error_code;
    logic       key_event;
    logic [7:0] key_value;
    logic [7:0] heart_rate;
    logic [7:0] belt_speed;
  } in_item_t;

  // decoded outcome of a completed receive frame
  typedef struct packed {
    logic            ok;
    logic [7:0]      cmd;
    logic [4:0][7:0] data;
    logic            beep;
    logic            study_write;
    logic [1:0]      study_value;
  } rx_evt_t;

  // everything one item leaves in the result register
  typedef struct packed {
    logic       reply;
    logic       frame_ok;
    logic       beep;
    logic       study_write;
    logic [1:0] study_value;
    logic       motor_flag_clear;
    logic       key_taken;
    logic [7:0] run_status;
    logic [7:0] speed_cmd;
    logic [7:0] grade_cmd;
    frame_t     frame;
  } result_t;

endpackage

// ===== hw/rtl/cfl_rx.sv =====
// receive frame assembler and command decoder
`timescale 1ns / 1ps

module cfl_rx (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_en,
  input  logic [7:0]          rx_byte,
  input  logic [1:0]          study_stage,
  output cfl_pkg::rx_evt_t    evt
);

  cfl_pkg::body_t rx_frame_r, rx_frame_nxt;
  logic [3:0]     rx_count_r, rx_count_nxt;
  logic [7:0]     body_sum;
  logic           at_end;

  // checksum over command and data bytes
  assign body_sum = rx_frame_r[1] + rx_frame_r[2] + rx_frame_r[3]
                  + rx_frame_r[4] + rx_frame_r[5] + rx_frame_r[6];
  assign at_end = (rx_count_r == 4'(cfl_pkg::BODY_LEN));

  // frame position tracking
  always_comb begin
    rx_frame_nxt = rx_frame_r;
    rx_count_nxt = rx_count_r;
    if (byte_en) begin
      if (rx_count_r == 4'd0) begin
        rx_frame_nxt[0] = rx_byte;
        rx_count_nxt    = (rx_byte == cfl_pkg::RX_HEADER) ? 4'd1 : 4'd0;
      end else if (!at_end) begin
        rx_frame_nxt[rx_count_r[2:0]] = rx_byte;
        rx_count_nxt = rx_count_r + 4'd1;
      end else begin
        rx_count_nxt = 4'd0;
      end
    end
  end

  // decode of the ninth byte
  always_comb begin
    evt = '0;
    evt.cmd  = rx_frame_r[1];
    evt.data = {rx_frame_r[6], rx_frame_r[5], rx_frame_r[4], rx_frame_r[3], rx_frame_r[2]};
    if (byte_en && at_end && rx_byte == cfl_pkg::RX_TRAILER && rx_frame_r[7] == body_sum) begin
      evt.ok = 1'b1;
      if (rx_frame_r[1] == cfl_pkg::CMD_RUN) begin
        evt.beep = (rx_frame_r[5] != 8'd0);
      end else if (rx_frame_r[1] == cfl_pkg::CMD_HEART) begin
        evt.beep = 1'b1;
      end else if (rx_frame_r[1] == cfl_pkg::CMD_STUDY &&
                   rx_frame_r[2] == cfl_pkg::STUDY_SELECT) begin
        if (rx_frame_r[3] == cfl_pkg::STUDY_REQ_START) begin
          if (study_stage == cfl_pkg::STAGE_IDLE) begin
            evt.study_write = 1'b1;
            evt.study_value = cfl_pkg::STUDY_VAL_START;
          end
        end else if (rx_frame_r[3] == cfl_pkg::STUDY_REQ_STOP) begin
          if (study_stage >= cfl_pkg::STAGE_RUNNING) begin
            evt.study_write = 1'b1;
            evt.study_value = cfl_pkg::STUDY_VAL_STOP;
          end
        end
      end
    end
  end

  // frame byte storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_count_r <= 4'd0;
      rx_frame_r <= '0;
    end else begin
      rx_count_r <= rx_count_nxt;
      rx_frame_r <= rx_frame_nxt;
    end
  end

endmodule

// ===== hw/rtl/cfl_ctrl.sv =====
// stored link settings, reply selection and result assembly
`timescale 1ns / 1ps

module cfl_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               move,
  input  cfl_pkg::in_item_t  item,
  input  cfl_pkg::rx_evt_t   evt,
  output cfl_pkg::result_t   res
);

  logic [7:0]      wheel_size_r, wheel_size_nxt;
  logic [3:0][7:0] echo_r, echo_nxt;
  logic [7:0]      spd_lo_r, spd_lo_nxt;
  logic [7:0]      spd_hi_r, spd_hi_nxt;
  logic [7:0]      inc_lo_r, inc_lo_nxt;
  logic [7:0]      inc_hi_r, inc_hi_nxt;
  logic [7:0]      status_r, status_nxt;
  logic [7:0]      grade_r, grade_nxt;
  logic [7:0]      speed_r, speed_nxt;
  logic            wheel_pend_r, wheel_pend_nxt;
  logic            lim_pend_r, lim_pend_nxt;
  logic            lim_valid_r, lim_valid_nxt;
  logic            toggle_r, toggle_nxt;

  logic            lim_ok;
  logic            is_reply;
  cfl_pkg::frame_t fr;

  assign is_reply = (item.req_type == cfl_pkg::REQ_REPLY);

  // stored limit sanity check ahead of a reply
  assign lim_ok = lim_valid_r
    && wheel_size_r != 8'd0 && wheel_size_r != cfl_pkg::BYTE_ALL_ONES
    && spd_lo_r != 8'd0 && spd_lo_r != cfl_pkg::BYTE_ALL_ONES
    && spd_hi_r != 8'd0 && spd_hi_r != cfl_pkg::BYTE_ALL_ONES
    && inc_hi_r < cfl_pkg::INCLINE_MAX;

  // next state and result for the beat in the input register
  always_comb begin
    wheel_size_nxt = wheel_size_r;
    echo_nxt       = echo_r;
    spd_lo_nxt     = spd_lo_r;
    spd_hi_nxt     = spd_hi_r;
    inc_lo_nxt     = inc_lo_r;
    inc_hi_nxt     = inc_hi_r;
    status_nxt     = status_r;
    grade_nxt      = grade_r;
    speed_nxt      = speed_r;
    wheel_pend_nxt = wheel_pend_r;
    lim_pend_nxt   = lim_pend_r;
    lim_valid_nxt  = lim_valid_r;
    toggle_nxt     = toggle_r;
    fr             = '0;
    res            = '0;

    if (is_reply) begin
      lim_valid_nxt = lim_ok;
      fr[0] = cfl_pkg::TX_HEADER;
      priority if (wheel_pend_r) begin
        wheel_pend_nxt = 1'b0;
        res.motor_flag_clear = 1'b1;
        fr[1] = cfl_pkg::CMD_WHEEL;
        fr[2] = wheel_size_r;
        fr[3] = echo_r[0];
        fr[4] = echo_r[1];
        fr[5] = echo_r[2];
        fr[6] = echo_r[3];
      end else if (lim_pend_r || !lim_ok) begin
        lim_pend_nxt = 1'b0;
        fr[1] = cfl_pkg::CMD_LIMITS;
        fr[2] = spd_lo_r;
        fr[3] = spd_hi_r;
        fr[4] = inc_lo_r;
        fr[5] = inc_hi_r;
        fr[6] = {7'd0, !lim_ok};
      end else if (item.error_code != 8'd0) begin
        fr[1] = cfl_pkg::CMD_ERROR;
        fr[2] = item.error_code;
      end else if (item.study_stage != cfl_pkg::STAGE_IDLE) begin
        fr[1] = cfl_pkg::CMD_STUDY;
        fr[2] = cfl_pkg::STUDY_REPLY_SUB;
        fr[3] = (item.study_stage == cfl_pkg::STAGE_SUCCESS) ?
                cfl_pkg::STUDY_RPT_DONE : cfl_pkg::STUDY_RPT_BUSY;
      end else if (item.key_event) begin
        res.key_taken = 1'b1;
        fr[1] = cfl_pkg::CMD_KEY;
        fr[2] = item.key_value;
      end else begin
        toggle_nxt = (status_r == cfl_pkg::STATUS_HOLD) ? 1'b0 : !toggle_r;
        if (!toggle_nxt) begin
          fr[1] = cfl_pkg::CMD_RUN;
          fr[2] = status_r;
          fr[3] = grade_r;
          fr[4] = speed_r;
          fr[5] = item.belt_speed;
        end else begin
          fr[1] = cfl_pkg::CMD_HEART;
          fr[2] = item.heart_rate;
        end
      end
      fr[7] = fr[1] + fr[2] + fr[3] + fr[4] + fr[5] + fr[6];
      fr[8] = cfl_pkg::TX_TRAILER;
    end else if (evt.ok) begin
      if (evt.cmd == cfl_pkg::CMD_WHEEL) begin
        wheel_pend_nxt = 1'b1;
        wheel_size_nxt = evt.data[0];
        echo_nxt       = {evt.data[4], evt.data[3], evt.data[2], evt.data[1]};
      end else if (evt.cmd == cfl_pkg::CMD_LIMITS) begin
        lim_pend_nxt  = 1'b1;
        lim_valid_nxt = 1'b1;
        spd_lo_nxt    = evt.data[0];
        spd_hi_nxt    = evt.data[1];
        inc_lo_nxt    = evt.data[2];
        inc_hi_nxt    = evt.data[3];
      end else if (evt.cmd == cfl_pkg::CMD_RUN) begin
        status_nxt = evt.data[0];
        grade_nxt  = evt.data[1];
        speed_nxt  = evt.data[2];
      end
    end

    res.reply       = is_reply;
    res.frame_ok    = evt.ok;
    res.beep        = evt.beep;
    res.study_write = evt.study_write;
    res.study_value = evt.study_value;
    res.run_status  = status_nxt;
    res.speed_cmd   = speed_nxt;
    res.grade_cmd   = grade_nxt;
    res.frame       = fr;
  end

  // settings and reply bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_size_r <= 8'd0;
      echo_r       <= '0;
      spd_lo_r     <= 8'd1;
      spd_hi_r     <= 8'd5;
      inc_lo_r     <= 8'd2;
      inc_hi_r     <= 8'd10;
      status_r     <= 8'd1;
      grade_r      <= 8'd0;
      speed_r      <= 8'd0;
      wheel_pend_r <= 1'b1;
      lim_pend_r   <= 1'b0;
      lim_valid_r  <= 1'b0;
      toggle_r     <= 1'b0;
    end else if (move) begin
      wheel_size_r <= wheel_size_nxt;
      echo_r       <= echo_nxt;
      spd_lo_r     <= spd_lo_nxt;
      spd_hi_r     <= spd_hi_nxt;
      inc_lo_r     <= inc_lo_nxt;
      inc_hi_r     <= inc_hi_nxt;
      status_r     <= status_nxt;
      grade_r      <= grade_nxt;
      speed_r      <= speed_nxt;
      wheel_pend_r <= wheel_pend_nxt;
      lim_pend_r   <= lim_pend_nxt;
      lim_valid_r  <= lim_valid_nxt;
      toggle_r     <= toggle_nxt;
    end
  end

endmodule

// ===== hw/rtl/cfl_out.sv =====
// result register and reply byte serializer
`timescale 1ns / 1ps

module cfl_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  cfl_pkg::result_t  res_in,
  input  logic              out_stall,
  output logic              free,
  output logic              out_valid,
  output logic [7:0]        tx_byte,
  output logic              last,
  output cfl_pkg::result_t  res_q
);

  logic                      valid_r, valid_nxt;
  logic [cfl_pkg::IDX_W-1:0] idx_r, idx_nxt;
  cfl_pkg::result_t          res_r;
  logic                      fire;

  assign fire      = valid_r && !out_stall;
  assign last      = !res_r.reply || (idx_r == cfl_pkg::LAST_IDX);
  assign free      = !valid_r || (fire && last);
  assign out_valid = valid_r;
  assign tx_byte   = res_r.reply ? res_r.frame[idx_r] : 8'd0;
  assign res_q     = res_r;

  // beat sequencing
  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = '0;
    end else if (fire) begin
      if (last) begin
        valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + cfl_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // payload holds until the next load
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

endmodule

// ===== hw/rtl/uart_command_frame_link.sv =====
// top level of the command frame link
`timescale 1ns / 1ps

// Command frame link. Each input beat is either one received link byte or a
// request to emit one reply frame. A received byte gives one result beat;
// a reply request gives nine result beats (0xFD, command, five data bytes,
// sum, 0xFE) with out_last on the ninth. An input beat is taken every cycle
// as long as results drain: one input register and one result register sit
// in line, and a reply holds the result register for nine output beats,
// during which at most one further input beat is held. Stored settings
// (wheel size, limits, run status) update when a beat moves from the input
// register to the result register.

module uart_command_frame_link (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_req_type,
  input  logic [7:0] in_rx_byte,
  input  logic [1:0] in_study_stage,
  input  logic [7:0] in_error_code,
  input  logic       in_key_event,
  input  logic [7:0] in_key_value,
  input  logic [7:0] in_heart_rate,
  input  logic [7:0] in_belt_speed,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_tx_byte,
  output logic       out_last,
  output logic       out_frame_ok,
  output logic       out_beep,
  output logic       out_study_write,
  output logic [1:0] out_study_value,
  output logic       out_motor_flag_clear,
  output logic       out_key_taken,
  output logic [7:0] out_run_status,
  output logic [7:0] out_speed_cmd,
  output logic [7:0] out_grade_cmd
);

  logic              in_valid_r, in_valid_nxt;
  cfl_pkg::in_item_t in_r;
  logic              in_take;
  logic              move;
  logic              out_free;
  cfl_pkg::rx_evt_t  evt;
  cfl_pkg::result_t  res;
  cfl_pkg::result_t  res_q;

  // input register handshake
  assign move         = in_valid_r && out_free;
  assign in_stall     = in_valid_r && !move;
  assign in_take      = in_valid && !in_stall;
  assign in_valid_nxt = in_take || (in_valid_r && !move);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= '{req_type:    in_req_type,
                rx_byte:     in_rx_byte,
                study_stage: in_study_stage,
                error_code:  in_error_code,
                key_event:   in_key_event,
                key_value:   in_key_value,
                heart_rate:  in_heart_rate,
                belt_speed:  in_belt_speed};
    end
  end

  // receive frame assembly
  cfl_rx u_rx (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_en     (move && in_r.req_type == cfl_pkg::REQ_RX),
    .rx_byte     (in_r.rx_byte),
    .study_stage (in_r.study_stage),
    .evt         (evt)
  );

  // settings and reply frame build
  cfl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .move  (move),
    .item  (in_r),
    .evt   (evt),
    .res   (res)
  );

  // result register and beat output
  cfl_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (move),
    .res_in    (res),
    .out_stall (out_stall),
    .free      (out_free),
    .out_valid (out_valid),
    .tx_byte   (out_tx_byte),
    .last      (out_last),
    .res_q     (res_q)
  );

  assign out_frame_ok         = res_q.frame_ok;
  assign out_beep             = res_q.beep;
  assign out_study_write      = res_q.study_write;
  assign out_study_value      = res_q.study_value;
  assign out_motor_flag_clear = res_q.motor_flag_clear;
  assign out_key_taken        = res_q.key_taken;
  assign out_run_status       = res_q.run_status;
  assign out_speed_cmd        = res_q.speed_cmd;
  assign out_grade_cmd        = res_q.grade_cmd;

endmodule
